>>> sv/angular_distance_delta_r_macros.svh
// Assertion macros used by the checker of the block.
`ifndef ANGULAR_DISTANCE_DELTA_R_MACROS_SVH
`define ANGULAR_DISTANCE_DELTA_R_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ADR_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("%m: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ADR_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

// Consequent in the next cycle, checked also while reset is applied.
`define ADR_ASSERT_NEXT_ALWAYS(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

>>> sv/adr_pkg.sv
package adr_pkg;

   localparam int PHI_BITS_DEF  = 10;
   localparam int FRAC_BITS_DEF = 4;
   localparam int ETA_W         = 12;
   localparam int DETA_W        = 12;
   localparam int DR_W          = 17;

endpackage

>>> sv/adr_if.sv
interface adr_req_if #(
   parameter int PHI_BITS = adr_pkg::PHI_BITS_DEF
);
   logic                            valid;
   logic                            ready;
   logic signed [adr_pkg::ETA_W-1:0] eta_a;
   logic        [PHI_BITS-1:0]       phi_a;
   logic signed [adr_pkg::ETA_W-1:0] eta_b;
   logic        [PHI_BITS-1:0]       phi_b;

   modport source (output valid, eta_a, phi_a, eta_b, phi_b, input ready);
   modport sink   (input valid, eta_a, phi_a, eta_b, phi_b, output ready);
endinterface

interface adr_rsp_if #(
   parameter int PHI_BITS = adr_pkg::PHI_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic [PHI_BITS-1:0]          abs_dphi;
   logic [adr_pkg::DETA_W-1:0]   abs_deta;
   logic [adr_pkg::DR_W-1:0]     delta_r;

   modport source (output valid, abs_dphi, abs_deta, delta_r, input ready);
   modport sink   (input valid, abs_dphi, abs_deta, delta_r, output ready);
endinterface

>>> sv/adr_sqrt_pipe.sv
module adr_sqrt_pipe #(
   parameter int RAD_W  = 33,
   parameter int SIDE_W = 22
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [RAD_W-1:0]            in_rad,
   input  logic [SIDE_W-1:0]           in_side,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [(RAD_W+1)/2-1:0]      out_root,
   output logic [SIDE_W-1:0]           out_side
);

   localparam int ROOT_W = (RAD_W + 1) / 2;
   localparam int RADE_W = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 1;
   localparam int ACC_W  = ROOT_W + 3;
   localparam int LAST   = ROOT_W - 1;

   // One result bit is settled in each stage, most significant first.
   logic                v_ff    [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];
   logic [SIDE_W-1:0]   side_ff [ROOT_W];
   logic [REM_W-1:0]    rem_ff  [LAST];
   logic [RADE_W-1:0]   rad_ff  [LAST];
   logic                en      [ROOT_W];
   logic [RADE_W-1:0]   rad_ext;

   assign rad_ext = RADE_W'(in_rad);

   genvar k;
   for (k = 0; k < ROOT_W; k++) begin : g_stage
      localparam int I = ROOT_W - 1 - k;
      logic                pv;
      logic [REM_W-1:0]    prem;
      logic [ROOT_W-1:0]   proot;
      logic [RADE_W-1:0]   prad;
      logic [SIDE_W-1:0]   pside;
      logic [ACC_W-1:0]    acc;
      logic [ACC_W-1:0]    trial;
      logic                ge;
      logic [ROOT_W-1:0]   root_in;

      if (k == 0) begin : g_first
         assign pv    = in_valid;
         assign prem  = '0;
         assign proot = '0;
         assign prad  = rad_ext;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = v_ff[k-1];
         assign prem  = rem_ff[k-1];
         assign proot = root_ff[k-1];
         assign prad  = rad_ff[k-1];
         assign pside = side_ff[k-1];
      end

      if (k == LAST) begin : g_en_last
         assign en[k] = !v_ff[k] || out_ready;
      end else begin : g_en_mid
         assign en[k] = !v_ff[k] || en[k+1];
      end

      assign acc     = {prem, prad[2*I+1:2*I]};
      assign trial   = {1'b0, proot, 2'b01};
      assign ge      = acc >= trial;
      assign root_in = {proot[ROOT_W-2:0], ge};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en[k]) begin
            v_ff[k] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            root_ff[k] <= root_in;
            side_ff[k] <= pside;
         end
      end

      if (k < LAST) begin : g_rem
         logic [ACC_W-1:0] diff;
         logic [REM_W-1:0] rem_in;

         assign diff   = acc - trial;
         assign rem_in = ge ? diff[REM_W-1:0] : acc[REM_W-1:0];

         always_ff @(posedge clock) begin
            if (en[k]) begin
               rem_ff[k] <= rem_in;
               rad_ff[k] <= prad;
            end
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[LAST];
   assign out_root  = root_ff[LAST];
   assign out_side  = side_ff[LAST];

endmodule

>>> sv/angular_distance_delta_r.sv
// Channel  Direction  Payload
// req      in         eta_a, phi_a, eta_b, phi_b
// rsp      out        abs_dphi, abs_deta, delta_r
//
// One transfer is taken in every cycle while req.ready is high. Most of the pipeline is
// the square root, which resolves one result bit per pipeline stage.
// Reset clears every valid bit; data registers are not reset.
// A stage holds only while the stage after it is full and stalled, so bubbles are
// squeezed out and req.ready falls only when the whole pipeline is full.
module angular_distance_delta_r #(
   parameter int PHI_BITS  = adr_pkg::PHI_BITS_DEF,
   parameter int FRAC_BITS = adr_pkg::FRAC_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   adr_req_if.sink   req,
   adr_rsp_if.source rsp
);

   localparam int ETA_W  = adr_pkg::ETA_W;
   localparam int DETA_W = adr_pkg::DETA_W;
   localparam int DR_W   = adr_pkg::DR_W;
   localparam int HALF   = 1 << (PHI_BITS - 1);
   localparam int SQP_W  = 2 * PHI_BITS;
   localparam int SQE_W  = 2 * DETA_W;
   localparam int SUM_W  = (((2 * PHI_BITS - 2) > SQE_W) ? (2 * PHI_BITS - 2) : SQE_W) + 1;
   localparam int RAD_W  = SUM_W + 2 * FRAC_BITS;
   localparam int ROOT_W = (RAD_W + 1) / 2;
   localparam int SIDE_W = PHI_BITS + DETA_W;

   logic en1, en2, en3, en_out;
   logic sq_in_ready;

   // Stage 1: absolute differences.
   logic [PHI_BITS-1:0] dphi;
   logic [ETA_W:0]      deta;
   logic [ETA_W:0]      deta_neg;
   logic [PHI_BITS-1:0] s1_adphi_in;
   logic [DETA_W-1:0]   s1_adeta_in;
   logic                s1_v_ff;
   logic [PHI_BITS-1:0] s1_adphi_ff;
   logic [DETA_W-1:0]   s1_adeta_ff;

   assign dphi        = req.phi_a - req.phi_b;
   assign s1_adphi_in = (dphi <= PHI_BITS'(HALF)) ? dphi : PHI_BITS'(0) - dphi;
   assign deta        = {req.eta_a[ETA_W-1], req.eta_a} - {req.eta_b[ETA_W-1], req.eta_b};
   assign deta_neg    = (ETA_W + 1)'(0) - deta;
   assign s1_adeta_in = deta[ETA_W] ? deta_neg[DETA_W-1:0] : deta[DETA_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en1) begin
         s1_v_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_adphi_ff <= s1_adphi_in;
         s1_adeta_ff <= s1_adeta_in;
      end
   end

   // Stage 2: squares.
   logic [SQP_W-1:0]    s2_sqp_in;
   logic [SQE_W-1:0]    s2_sqe_in;
   logic                s2_v_ff;
   logic [SQP_W-1:0]    s2_sqp_ff;
   logic [SQE_W-1:0]    s2_sqe_ff;
   logic [PHI_BITS-1:0] s2_adphi_ff;
   logic [DETA_W-1:0]   s2_adeta_ff;

   assign s2_sqp_in = SQP_W'(s1_adphi_ff) * SQP_W'(s1_adphi_ff);
   assign s2_sqe_in = SQE_W'(s1_adeta_ff) * SQE_W'(s1_adeta_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en2) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_sqp_ff   <= s2_sqp_in;
         s2_sqe_ff   <= s2_sqe_in;
         s2_adphi_ff <= s1_adphi_ff;
         s2_adeta_ff <= s1_adeta_ff;
      end
   end

   // Stage 3: sum of squares, scaled for the fraction bits of the root.
   logic [RAD_W-1:0]  s3_rad_in;
   logic              s3_v_ff;
   logic [RAD_W-1:0]  s3_rad_ff;
   logic [SIDE_W-1:0] s3_side_ff;

   assign s3_rad_in = (RAD_W'(s2_sqp_ff) + RAD_W'(s2_sqe_ff)) << (2 * FRAC_BITS);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en3) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_rad_ff  <= s3_rad_in;
         s3_side_ff <= {s2_adphi_ff, s2_adeta_ff};
      end
   end

   // Square root stages.
   logic              sq_out_valid;
   logic [ROOT_W-1:0] sq_root;
   logic [SIDE_W-1:0] sq_side;

   adr_sqrt_pipe #(
      .RAD_W  (RAD_W),
      .SIDE_W (SIDE_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_v_ff),
      .in_ready  (sq_in_ready),
      .in_rad    (s3_rad_ff),
      .in_side   (s3_side_ff),
      .out_valid (sq_out_valid),
      .out_ready (en_out),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   // Output register with saturation of the root.
   logic [DR_W-1:0]     dr_in;
   logic                out_v_ff;
   logic [PHI_BITS-1:0] out_adphi_ff;
   logic [DETA_W-1:0]   out_adeta_ff;
   logic [DR_W-1:0]     out_dr_ff;

   if (ROOT_W > DR_W) begin : g_sat
      assign dr_in = (|sq_root[ROOT_W-1:DR_W]) ? '1 : sq_root[DR_W-1:0];
   end else begin : g_nosat
      assign dr_in = DR_W'(sq_root);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en_out) begin
         out_v_ff <= sq_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         out_adphi_ff <= sq_side[SIDE_W-1:DETA_W];
         out_adeta_ff <= sq_side[DETA_W-1:0];
         out_dr_ff    <= dr_in;
      end
   end

   assign en_out = !out_v_ff || rsp.ready;
   assign en3    = !s3_v_ff || sq_in_ready;
   assign en2    = !s2_v_ff || en3;
   assign en1    = !s1_v_ff || en2;

   assign req.ready    = en1;
   assign rsp.valid    = out_v_ff;
   assign rsp.abs_dphi = out_adphi_ff;
   assign rsp.abs_deta = out_adeta_ff;
   assign rsp.delta_r  = out_dr_ff;

endmodule

>>> sv/adr_checker.sv
`include "angular_distance_delta_r_macros.svh"

module adr_checker #(
   parameter int PHI_BITS  = adr_pkg::PHI_BITS_DEF,
   parameter int FRAC_BITS = adr_pkg::FRAC_BITS_DEF
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [PHI_BITS-1:0]         rsp_abs_dphi,
   input logic [adr_pkg::DETA_W-1:0]  rsp_abs_deta,
   input logic [adr_pkg::DR_W-1:0]    rsp_delta_r
);

   localparam int DR_W   = adr_pkg::DR_W;
   localparam int HALF   = 1 << (PHI_BITS - 1);
   localparam int DR_MAX = (1 << DR_W) - 1;

   logic        dr_sat;
   logic [31:0] deta_scaled;

   assign dr_sat      = rsp_delta_r == DR_W'(DR_MAX);
   assign deta_scaled = 32'(rsp_abs_deta) << FRAC_BITS;

   // A result stays offered until it is taken.
   `ADR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

   // Nothing is offered right after reset.
   `ADR_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_valid)

   // The input side stalls only when the pipeline is full up to a stalled output.
   `ADR_ASSERT_SAME(a_stall_full, req_valid && !req_ready, rsp_valid && !rsp_ready)

   // The folded azimuth never exceeds half a turn.
   `ADR_ASSERT_SAME(a_dphi_range, rsp_valid, rsp_abs_dphi <= PHI_BITS'(HALF))

   // The distance is never shorter than the eta difference alone, unless saturated.
   `ADR_ASSERT_SAME(a_dr_bound, rsp_valid && !dr_sat, deta_scaled <= 32'(rsp_delta_r))

endmodule

bind angular_distance_delta_r adr_checker #(
   .PHI_BITS  (PHI_BITS),
   .FRAC_BITS (FRAC_BITS)
) u_adr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_abs_dphi (rsp.abs_dphi),
   .rsp_abs_deta (rsp.abs_deta),
   .rsp_delta_r  (rsp.delta_r)
);
